>>> rtl/blr_pkg.sv
// Package for the line rasterizer: coordinate widths, command and status types.
// No dependencies; used by every other file of the block.
package blr_pkg;

   localparam int COORD_BITS = 6;
   localparam int COLOR_BITS = 16;
   // Error term: room for twice the largest delta plus sign.
   localparam int ERR_BITS   = COORD_BITS + 3;

   typedef logic [COORD_BITS-1:0]        coord_type;
   typedef logic [COLOR_BITS-1:0]        color_type;
   typedef logic signed [ERR_BITS-1:0]   err_type;
   typedef logic signed [ERR_BITS:0]     err2_type;

   typedef enum logic [1:0] {
      KIND_GENERAL    = 2'd0,
      KIND_VERTICAL   = 2'd1,
      KIND_HORIZONTAL = 2'd2
   } line_kind_type;

   // Walk command, normalized so that axis lines run low to high.
   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type ex;
      coord_type ey;
      coord_type dx;       // |ex - x|
      coord_type dy;       // |ey - y|
      logic      sx_neg;   // x steps down
      logic      sy_neg;   // y steps down
      color_type color;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

>>> rtl/blr_channels_if.sv
// Valid/ready channel interfaces for line commands and pixel writes.
// Depends on blr_pkg for coordinate and color types.
interface blr_req_if;
   logic                valid;
   logic                ready;
   blr_pkg::coord_type  start_x;
   blr_pkg::coord_type  start_y;
   blr_pkg::coord_type  end_x;
   blr_pkg::coord_type  end_y;
   blr_pkg::color_type  pen_color;

   modport source (output valid, start_x, start_y, end_x, end_y, pen_color, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, pen_color, output ready);
endinterface

interface blr_rsp_if;
   logic                valid;
   logic                ready;
   blr_pkg::coord_type  pixel_x;
   blr_pkg::coord_type  pixel_y;
   blr_pkg::color_type  pixel_color;
   logic                last_pixel;

   modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

>>> rtl/blr_front.sv
// Front end: accepts line commands, classifies them and builds walk commands.
// Depends on blr_pkg and blr_req_if.
module blr_front (
   blr_req_if.sink          req,
   input  logic             q_full,
   output logic             q_push,
   output blr_pkg::cmd_type q_cmd
);
   import blr_pkg::*;

   line_kind_type kind;
   coord_type     x0, y0, x1, y1;

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   always_comb begin
      if (req.start_x == req.end_x) begin
         kind = KIND_VERTICAL;
      end else if (req.start_y == req.end_y) begin
         kind = KIND_HORIZONTAL;
      end else begin
         kind = KIND_GENERAL;
      end
   end

   // Axis lines are emitted from the smaller to the larger coordinate.
   always_comb begin
      x0 = req.start_x;
      y0 = req.start_y;
      x1 = req.end_x;
      y1 = req.end_y;
      unique case (kind)
         KIND_VERTICAL: begin
            if (req.start_y > req.end_y) begin
               y0 = req.end_y;
               y1 = req.start_y;
            end
         end
         KIND_HORIZONTAL: begin
            if (req.start_x > req.end_x) begin
               x0 = req.end_x;
               x1 = req.start_x;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      q_cmd.x      = x0;
      q_cmd.y      = y0;
      q_cmd.ex     = x1;
      q_cmd.ey     = y1;
      q_cmd.dx     = (x1 > x0) ? coord_type'(x1 - x0) : coord_type'(x0 - x1);
      q_cmd.dy     = (y1 > y0) ? coord_type'(y1 - y0) : coord_type'(y0 - y1);
      q_cmd.sx_neg = !(x0 < x1);
      q_cmd.sy_neg = !(y0 < y1);
      q_cmd.color  = req.pen_color;
   end

endmodule

>>> rtl/blr_cmd_queue.sv
// Two-entry command queue between front end and pixel walker.
// Depends on blr_pkg.
module blr_cmd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  blr_pkg::cmd_type      push_cmd,
   input  logic                  pop,
   output blr_pkg::q_status_type status,
   output blr_pkg::cmd_type      head
);
   import blr_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign status = '{full: (count_ff == 2'd2), empty: (count_ff == 2'd0)};
   assign head   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/blr_back.sv
// Back end: walks a line by integer error term, one pixel a cycle if rsp ready.
// Depends on blr_pkg and blr_rsp_if.
module blr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  blr_pkg::q_status_type q_status,
   input  blr_pkg::cmd_type      q_head,
   output logic                  q_pop,
   blr_rsp_if.source             rsp
);
   import blr_pkg::*;

   logic      busy_ff, busy_in;
   coord_type x_ff, x_in, y_ff, y_in;
   coord_type ex_ff, ey_ff, dx_ff, dy_ff;
   logic      sx_neg_ff, sy_neg_ff;
   color_type color_ff;
   err_type   err_ff, err_in;

   err_type   dx_w, dy_w, load_dx, load_dy;
   err2_type  e2;
   logic      step_x, step_y, last, xfer;

   assign last = (x_ff == ex_ff) && (y_ff == ey_ff);
   assign xfer = busy_ff && rsp.ready;

   assign rsp.valid       = busy_ff;
   assign rsp.pixel_x     = x_ff;
   assign rsp.pixel_y     = y_ff;
   assign rsp.pixel_color = color_ff;
   assign rsp.last_pixel  = last;

   // Next command loads as the last pixel of the current one goes out.
   assign q_pop = !q_status.empty && (!busy_ff || (xfer && last));

   assign dx_w    = err_type'({{(ERR_BITS-COORD_BITS){1'b0}}, dx_ff});
   assign dy_w    = err_type'({{(ERR_BITS-COORD_BITS){1'b0}}, dy_ff});
   assign load_dx = err_type'({{(ERR_BITS-COORD_BITS){1'b0}}, q_head.dx});
   assign load_dy = err_type'({{(ERR_BITS-COORD_BITS){1'b0}}, q_head.dy});
   assign e2      = err2_type'({err_ff, 1'b0});
   assign step_x  = e2 >= -err2_type'(dy_w);
   assign step_y  = e2 <= err2_type'(dx_w);

   always_comb begin
      busy_in = busy_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      err_in  = err_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         x_in    = q_head.x;
         y_in    = q_head.y;
         err_in  = load_dx - load_dy;
      end else if (xfer) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            err_in = err_ff + (step_x ? -dy_w : '0) + (step_y ? dx_w : '0);
            if (step_x) begin
               x_in = sx_neg_ff ? coord_type'(x_ff - 1'b1) : coord_type'(x_ff + 1'b1);
            end
            if (step_y) begin
               y_in = sy_neg_ff ? coord_type'(y_ff - 1'b1) : coord_type'(y_ff + 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      err_ff <= err_in;
      if (q_pop) begin
         ex_ff     <= q_head.ex;
         ey_ff     <= q_head.ey;
         dx_ff     <= q_head.dx;
         dy_ff     <= q_head.dy;
         sx_neg_ff <= q_head.sx_neg;
         sy_neg_ff <= q_head.sy_neg;
         color_ff  <= q_head.color;
      end
   end

endmodule

>>> rtl/bresenham_line_rasterizer_core.sv
// Top level of the line rasterizer: front end, command queue, pixel walker.
// Depends on blr_pkg, blr_channels_if, blr_front, blr_cmd_queue, blr_back.
//
//   channel  dir  one transfer carries
//   -------  ---  ----------------------------------------------
//   req      in   start_x, start_y, end_x, end_y, pen_color
//   rsp      out  pixel_x, pixel_y, pixel_color, last_pixel
//
// A line of N = max(|dx|,|dy|)+1 pixels is walked by the walker's one-step error update,
// one pixel per rsp transfer; the next queued line loads as its last pixel goes out.
// A command goes into the queue, then the walker load, before its first pixel is valid.
// The two-entry queue takes new commands until full while the walker is stalled on rsp.
// Reset is synchronous, active high; it empties the queue and idles the walker.
module bresenham_line_rasterizer_core (
   input  logic     clock,
   input  logic     reset,
   blr_req_if.sink  req,
   blr_rsp_if.source rsp
);
   import blr_pkg::*;

   logic         q_push, q_pop;
   cmd_type      q_in_cmd, q_head;
   q_status_type q_status;

   // Classify and normalize each command on its way into the queue.
   blr_front u_front (
      .req    (req),
      .q_full (q_status.full),
      .q_push (q_push),
      .q_cmd  (q_in_cmd)
   );

   // Decouples command acceptance from pixel output stalls.
   blr_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_in_cmd),
      .pop      (q_pop),
      .status   (q_status),
      .head     (q_head)
   );

   // Error-term walker, one pixel per rsp transfer.
   blr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp      (rsp)
   );

   // Queue never written while full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("command queue overflow");

   // A line keeps going until its flagged pixel.
   a_line_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && !rsp.last_pixel) |=> rsp.valid)
      else $error("line ended without last pixel");

   // Consecutive pixels of a line differ by at most one step in x.
   a_x_step: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && !rsp.last_pixel) |=>
         (coord_type'(rsp.pixel_x - $past(rsp.pixel_x)) == coord_type'(0) ||
          coord_type'(rsp.pixel_x - $past(rsp.pixel_x)) == coord_type'(1) ||
          coord_type'($past(rsp.pixel_x) - rsp.pixel_x) == coord_type'(1)))
      else $error("x jumped by more than one");

   // Color is constant within a line.
   a_color_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && !rsp.last_pixel) |=>
         (rsp.pixel_color == $past(rsp.pixel_color)))
      else $error("color changed within a line");

endmodule
